// File: sv/bmpr_pkg.sv
// Shared types and constants for the 90-degree pixel rotator.
// No dependencies; used by the interfaces, the core and its checker.
package bmpr_pkg;

   localparam int unsigned CSR_W           = 8;
   localparam int unsigned CSR_IDX_W       = 1;
   localparam int unsigned MAX_DIM_DEFAULT = 128;
   localparam int unsigned IMG_DIM_RESET   = 128;
   localparam int unsigned PIXEL_W         = 24;
   localparam int unsigned BYTE_W          = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMG_WIDTH  = 1'b0,
      CSR_IMG_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_FETCH = 1'b1
   } command_type;

   // what travels alongside the store read
   typedef struct packed {
      logic       pad;
      logic [1:0] byte_sel;
      logic       last;
   } fetch_meta_type;

endpackage

// File: sv/bmpr_req_if.sv
// Request channel: load or fetch command with one source byte.
// Depends on bmpr_pkg for the byte width.
interface bmpr_req_if;
   import bmpr_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output command, output in_byte, input ready);
   modport sink (input valid, input command, input in_byte, output ready);
endinterface

// File: sv/bmpr_rsp_if.sv
// Response channel: one rotated byte with its end-of-array flag.
// Depends on bmpr_pkg for the byte width.
interface bmpr_rsp_if;
   import bmpr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: sv/bmp_pixel_rotate_90_core.sv
// 90-degree rotator for 24-bit bottom-up pixel arrays, with on-chip pixel store.
// Depends on bmpr_pkg, bmpr_req_if and bmpr_rsp_if.
//
// Usage:
//  - req_ch carries items: command 0 loads one source byte (row by row, row
//    padding included), command 1 fetches one byte of the rotated array.
//  - rsp_ch returns one item per fetch once a full image is loaded; fetches
//    before that are taken and dropped. last_byte marks the final byte, after
//    which fetching wraps to the first byte again.
//  - csr_we/csr_index/csr_wdata set width and height; any write restarts the
//    load and clears the loaded image. Write only while the block is idle.
//  - One item is accepted per cycle while req_ch.ready is high. A fetch passes
//    through the registered pixel store read, then the output register, before
//    it shows on rsp_ch. Loads give no response.
//  - When rsp_ch stalls, the store read stage holds one more fetch, then
//    req_ch.ready drops until the output register drains.
//  - Synchronous reset clears control state and sets both dimensions to 128
//    (clipped to MAX_DIM); the pixel store is not cleared and needs no pass.
module bmp_pixel_rotate_90_core #(
   parameter int unsigned MAX_DIM = bmpr_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   bmpr_req_if.sink                        req_ch,
   bmpr_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [bmpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmpr_pkg::CSR_W-1:0]      csr_wdata
);
   import bmpr_pkg::*;

   localparam int unsigned DW    = $clog2(MAX_DIM + 1);
   localparam int unsigned CW    = (CSR_W > DW) ? CSR_W : DW;
   localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned DIM_RST = (IMG_DIM_RESET > MAX_DIM) ? MAX_DIM : IMG_DIM_RESET;

   // dimensions, held already clipped
   logic [DW-1:0] w_ff, w_in, h_ff, h_in, csr_eff;
   logic [CW-1:0] csr_wide;

   // load progress
   logic [DW-1:0]       lrow_ff, lrow_in, lcol_ff, lcol_in;
   logic [1:0]          lphase_ff, lphase_in, lpad_ff, lpad_in;
   logic [2*BYTE_W-1:0] partial_ff, partial_in;
   logic                loaded_ff, loaded_in;

   // emit progress
   logic [DW-1:0] erow_ff, erow_in, ej_ff, ej_in;
   logic [1:0]    ek_ff, ek_in, epcnt_ff, epcnt_in;
   logic          epad_ff, epad_in;

   // pipeline
   logic              s1_valid_ff, s1_valid_in;
   fetch_meta_type    s1_meta_ff, s1_meta_in;
   logic [PIXEL_W-1:0] rdata_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;

   logic          req_go, load_go, fetch_go, out_free, s1_move;
   logic [1:0]    w_mod4, h_mod4;
   logic [DW-1:0] ecol;
   logic          row_end, emit_last;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_move      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_go       = req_ch.valid && req_ch.ready;
   assign load_go      = req_go && (req_ch.command == CMD_LOAD);
   assign fetch_go     = req_go && (req_ch.command == CMD_FETCH) && loaded_ff;

   assign w_mod4 = 2'(w_ff);
   assign h_mod4 = 2'(h_ff);

   // clip a written dimension into 1..MAX_DIM
   always_comb begin
      csr_wide = CW'(csr_wdata);
      if (csr_wide == '0) begin
         csr_eff = DW'(1);
      end else if (csr_wide > CW'(MAX_DIM)) begin
         csr_eff = DW'(MAX_DIM);
      end else begin
         csr_eff = DW'(csr_wide);
      end
   end

   // load path
   always_comb begin
      lrow_in    = lrow_ff;
      lcol_in    = lcol_ff;
      lphase_in  = lphase_ff;
      lpad_in    = lpad_ff;
      partial_in = partial_ff;
      loaded_in  = loaded_ff;
      mem_we     = 1'b0;
      mem_waddr  = AW'(lrow_ff) * AW'(MAX_DIM) + AW'(lcol_ff);
      if (load_go) begin
         loaded_in = 1'b0;
         if (lpad_ff != 2'd0) begin
            lpad_in = lpad_ff - 2'd1;
            if (lpad_ff == 2'd1) begin
               lcol_in = '0;
               if (lrow_ff == h_ff - DW'(1)) begin
                  lrow_in   = '0;
                  loaded_in = 1'b1;
               end else begin
                  lrow_in = lrow_ff + DW'(1);
               end
            end
         end else begin
            case (lphase_ff)
               2'd0: begin
                  partial_in[BYTE_W-1:0] = req_ch.in_byte;
                  lphase_in              = 2'd1;
               end
               2'd1: begin
                  partial_in[2*BYTE_W-1:BYTE_W] = req_ch.in_byte;
                  lphase_in                     = 2'd2;
               end
               default: begin
                  mem_we    = 1'b1;
                  lphase_in = 2'd0;
                  lcol_in   = lcol_ff + DW'(1);
                  if (lcol_ff == w_ff - DW'(1)) begin
                     lcol_in = '0;
                     if (w_mod4 != 2'd0) begin
                        lpad_in = w_mod4;
                     end else if (lrow_ff == h_ff - DW'(1)) begin
                        lrow_in   = '0;
                        loaded_in = 1'b1;
                     end else begin
                        lrow_in = lrow_ff + DW'(1);
                     end
                  end
               end
            endcase
         end
      end
   end

   // fetch path
   assign ecol      = w_ff - DW'(1) - erow_ff;
   assign mem_raddr = AW'(ej_ff) * AW'(MAX_DIM) + AW'(ecol);
   assign row_end   = (h_mod4 == 2'd0)
                      ? (!epad_ff && ej_ff == h_ff - DW'(1) && ek_ff == 2'd2)
                      : (epad_ff && epcnt_ff == h_mod4 - 2'd1);
   assign emit_last = (erow_ff == w_ff - DW'(1)) && row_end;

   always_comb begin
      erow_in  = erow_ff;
      ej_in    = ej_ff;
      ek_in    = ek_ff;
      epad_in  = epad_ff;
      epcnt_in = epcnt_ff;
      if (load_go) begin
         erow_in  = '0;
         ej_in    = '0;
         ek_in    = '0;
         epad_in  = 1'b0;
         epcnt_in = '0;
      end else if (fetch_go) begin
         if (row_end) begin
            ej_in    = '0;
            ek_in    = '0;
            epad_in  = 1'b0;
            epcnt_in = '0;
            erow_in  = (erow_ff == w_ff - DW'(1)) ? '0 : erow_ff + DW'(1);
         end else if (epad_ff) begin
            epcnt_in = epcnt_ff + 2'd1;
         end else if (ek_ff == 2'd2) begin
            ek_in = '0;
            if (ej_ff == h_ff - DW'(1)) begin
               epad_in = 1'b1;
            end else begin
               ej_in = ej_ff + DW'(1);
            end
         end else begin
            ek_in = ek_ff + 2'd1;
         end
      end
   end

   always_comb begin
      s1_meta_in.pad      = epad_ff;
      s1_meta_in.byte_sel = ek_ff;
      s1_meta_in.last     = emit_last;
      s1_valid_in = fetch_go ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : ((out_valid_ff && rsp_ch.ready) ? 1'b0 : out_valid_ff);
      out_last_in = s1_meta_ff.last;
      if (s1_meta_ff.pad) begin
         out_byte_in = '0;
      end else begin
         case (s1_meta_ff.byte_sel)
            2'd0:    out_byte_in = rdata_ff[BYTE_W-1:0];
            2'd1:    out_byte_in = rdata_ff[2*BYTE_W-1:BYTE_W];
            default: out_byte_in = rdata_ff[3*BYTE_W-1:2*BYTE_W];
         endcase
      end
   end

   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMG_WIDTH:  w_in = csr_eff;
            CSR_IMG_HEIGHT: h_in = csr_eff;
            default:        w_in = w_ff;
         endcase
      end
   end

   // pixel store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= {req_ch.in_byte, partial_ff};
      end
      if (fetch_go) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= DW'(DIM_RST);
         h_ff         <= DW'(DIM_RST);
         lrow_ff      <= '0;
         lcol_ff      <= '0;
         lphase_ff    <= '0;
         lpad_ff      <= '0;
         partial_ff   <= '0;
         loaded_ff    <= 1'b0;
         erow_ff      <= '0;
         ej_ff        <= '0;
         ek_ff        <= '0;
         epad_ff      <= 1'b0;
         epcnt_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (csr_we) begin
         w_ff         <= w_in;
         h_ff         <= h_in;
         lrow_ff      <= '0;
         lcol_ff      <= '0;
         lphase_ff    <= '0;
         lpad_ff      <= '0;
         partial_ff   <= '0;
         loaded_ff    <= 1'b0;
         erow_ff      <= '0;
         ej_ff        <= '0;
         ek_ff        <= '0;
         epad_ff      <= 1'b0;
         epcnt_ff     <= '0;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end else begin
         lrow_ff      <= lrow_in;
         lcol_ff      <= lcol_in;
         lphase_ff    <= lphase_in;
         lpad_ff      <= lpad_in;
         partial_ff   <= partial_in;
         loaded_ff    <= loaded_in;
         erow_ff      <= erow_in;
         ej_ff        <= ej_in;
         ek_ff        <= ek_in;
         epad_ff      <= epad_in;
         epcnt_ff     <= epcnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_go) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_move) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_byte  = out_byte_ff;
   assign rsp_ch.last_byte = out_last_ff;

endmodule

// File: sv/bmpr_checker.sv
// Port-level checks for bmp_pixel_rotate_90_core, attached by bind.
// Depends on bmpr_pkg for the byte width.
module bmpr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bmpr_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_last_byte
);
   import bmpr_pkg::*;

   // output stalled: held item stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last_byte))
      else $error("rsp payload changed while stalled");

   // no item can reach the output right after reset: both stages start empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("rsp item too soon after reset");

   // a free output register always lets requests in
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req stalled with output free");

endmodule

bind bmp_pixel_rotate_90_core bmpr_checker u_bmpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_last_byte (rsp_ch.last_byte)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for bmp_pixel_rotate_90_core: streams source images and fetches,
// predicts every rotated byte and compares it on the response channel.
// Depends on bmpr_pkg, bmpr_req_if, bmpr_rsp_if and the core.
module tb_top;
   import bmpr_pkg::*;

   localparam int unsigned MAX_DIM        = MAX_DIM_DEFAULT;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned RANDOM_ITEMS   = 700;
   localparam int unsigned EDGE_FETCHES   = 64;

   typedef struct packed {
      command_type       cmd;
      logic [BYTE_W-1:0] data;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
   } rotated_byte_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   bmpr_req_if req ();
   bmpr_rsp_if rsp ();

   bmp_pixel_rotate_90_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   req_item_type     req_q[$];
   rotated_byte_type rotated_q[$];
   req_item_type     next_item;

   // bench control
   logic        calm           = 1'b0;
   logic        req_idle_on    = 1'b1;
   logic        rsp_idle_on    = 1'b1;
   logic        long_hold_req  = 1'b0;
   logic        long_hold_done = 1'b0;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned hold_left;
   int unsigned quiet_cycles;

   int unsigned fail_count     = 0;
   int unsigned queued_items   = 0;
   int unsigned loads_taken    = 0;
   int unsigned bytes_compared = 0;
   int unsigned images_done    = 0;
   int unsigned dim_writes     = 0;

   // rotator state as the bench sees it
   bit [PIXEL_W-1:0] pixel_mem [MAX_DIM*MAX_DIM];
   int unsigned      src_row, src_col, src_phase, src_pad_left;
   bit [15:0]        src_partial;
   bit               image_ready;
   int unsigned      out_row, out_pos;
   bit [CSR_W-1:0]   cfg_width  = 8'd128;
   bit [CSR_W-1:0]   cfg_height = 8'd128;

   function automatic int unsigned clip_dim(input bit [CSR_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_DIM)
         return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic int unsigned row_pad(input int unsigned pixels);
      return (4 - (pixels * 3) % 4) % 4;
   endfunction

   function automatic void restart_image();
      src_row      = 0;
      src_col      = 0;
      src_phase    = 0;
      src_pad_left = 0;
      src_partial  = '0;
      image_ready  = 1'b0;
      out_row      = 0;
      out_pos      = 0;
   endfunction

   function automatic void close_source_row(input int unsigned h);
      src_col = 0;
      src_row++;
      if (src_row >= h) begin
         src_row     = 0;
         image_ready = 1'b1;
         out_row     = 0;
         out_pos     = 0;
         images_done++;
      end
   endfunction

   task automatic rotate_predict(input command_type cmd, input logic [BYTE_W-1:0] b);
      int unsigned      w, h, data_len, row_len;
      bit [PIXEL_W-1:0] pix;
      rotated_byte_type exp_byte;
      w = clip_dim(cfg_width);
      h = clip_dim(cfg_height);
      if (cmd == CMD_LOAD) begin
         if (image_ready)
            restart_image();
         if (src_pad_left != 0) begin
            src_pad_left--;
            if (src_pad_left == 0)
               close_source_row(h);
         end else if (src_phase == 0) begin
            src_partial = {8'h00, b};
            src_phase   = 1;
         end else if (src_phase == 1) begin
            src_partial[15:8] = b;
            src_phase         = 2;
         end else begin
            pixel_mem[src_row * MAX_DIM + src_col] = {b, src_partial};
            src_phase   = 0;
            src_partial = '0;
            src_col++;
            if (src_col >= w) begin
               if (row_pad(w) != 0) begin
                  src_pad_left = row_pad(w);
                  src_col      = 0;
               end else begin
                  close_source_row(h);
               end
            end
         end
      end else if (image_ready) begin
         data_len = h * 3;
         row_len  = data_len + row_pad(h);
         exp_byte.out_byte = '0;
         if (out_pos < data_len && out_row < w) begin
            pix = pixel_mem[(out_pos / 3) * MAX_DIM + (w - 1 - out_row)];
            exp_byte.out_byte = BYTE_W'(pix >> (8 * (out_pos % 3)));
         end
         exp_byte.last_byte = (out_row + 1 >= w) && (out_pos + 1 >= row_len);
         rotated_q.push_back(exp_byte);
         out_pos++;
         if (out_pos >= row_len) begin
            out_pos = 0;
            out_row++;
            if (out_row >= w)
               out_row = 0;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid   <= 1'b0;
         req.command <= CMD_LOAD;
         req.in_byte <= '0;
         gap_left    <= 0;
      end else if (!req.valid || req.ready) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req.valid <= 1'b0;
         end else if (req_idle_on && !calm && req_q.size() != 0 &&
                      $urandom_range(0, 9) == 0) begin
            gap_left  <= $urandom_range(0, 9);
            req.valid <= 1'b0;
         end else if (req_q.size() != 0) begin
            next_item    = req_q.pop_front();
            req.valid   <= 1'b1;
            req.command <= next_item.cmd;
            req.in_byte <= next_item.data;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // response side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         hold_left      <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
         rsp.ready      <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else if (rsp_idle_on && !calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_IMG_WIDTH)
               cfg_width = csr_wdata;
            else
               cfg_height = csr_wdata;
            restart_image();
            dim_writes++;
         end
         if (req.valid && req.ready) begin
            if (req.command == CMD_LOAD)
               loads_taken++;
            rotate_predict(command_type'(req.command), req.in_byte);
         end
         if (rsp.valid && rsp.ready) begin
            if (rotated_q.size() == 0) begin
               $error("out_byte: no item expected, got %0h (last_byte %0b)",
                      rsp.out_byte, rsp.last_byte);
               fail_count++;
            end else begin
               bytes_compared++;
               if (rsp.out_byte !== rotated_q[0].out_byte) begin
                  $error("out_byte: expected %0h, got %0h",
                         rotated_q[0].out_byte, rsp.out_byte);
                  fail_count++;
               end
               if (rsp.last_byte !== rotated_q[0].last_byte) begin
                  $error("last_byte: expected %0b, got %0b",
                         rotated_q[0].last_byte, rsp.last_byte);
                  fail_count++;
               end
               void'(rotated_q.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_item(input command_type cmd, input logic [BYTE_W-1:0] data,
                            input bit counted);
      req_q.push_back('{cmd: cmd, data: data});
      if (counted)
         queued_items++;
   endtask

   task automatic push_image(input int unsigned w, input int unsigned h, input bit noisy);
      int unsigned n;
      n = h * (3 * w + row_pad(w));
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            push_item(CMD_FETCH, BYTE_W'($urandom_range(0, 255)), 1'b0);
         push_item(CMD_LOAD, BYTE_W'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic push_fetches(input int unsigned n, input bit counted);
      for (int unsigned i = 0; i < n; i++)
         push_item(CMD_FETCH, BYTE_W'($urandom_range(0, 255)), counted);
   endtask

   // wait until the block has nothing in flight
   task automatic settle();
      @(negedge clock);
      while (req_q.size() != 0 || req.valid || rotated_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_dim(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase();
      int unsigned    w, h, img_len, out_len, pick;
      logic [CSR_W-1:0] wr, hr;
      if (dim_writes < 8 || $urandom_range(0, 2) != 0) begin
         settle();
         req_idle_on <= ($urandom_range(0, 3) != 0);
         rsp_idle_on <= ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 7);
         if (pick == 0) begin
            wr = CSR_W'($urandom_range(7, 24));
            hr = CSR_W'($urandom_range(0, 3));
         end else if (pick == 1) begin
            wr = CSR_W'($urandom_range(0, 3));
            hr = CSR_W'($urandom_range(7, 24));
         end else begin
            wr = CSR_W'($urandom_range(0, 6));
            hr = CSR_W'($urandom_range(0, 6));
         end
         pick = $urandom_range(0, 5);
         if (pick != 2)
            write_dim(CSR_IMG_WIDTH, wr);
         if (pick != 1)
            write_dim(CSR_IMG_HEIGHT, hr);
      end
      @(negedge clock);
      w       = clip_dim(cfg_width);
      h       = clip_dim(cfg_height);
      img_len = h * (3 * w + row_pad(w));
      out_len = w * (3 * h + row_pad(h));
      if ($urandom_range(0, 4) != 0) begin
         push_fetches($urandom_range(0, 2), 1'b0);
         push_image(w, h, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 0)
            push_fetches(out_len, 1'b1);
         else
            push_fetches($urandom_range(1, 2 * out_len + 1), 1'b1);
      end else begin
         for (int unsigned i = $urandom_range(1, img_len - 1); i != 0; i--)
            push_item(CMD_LOAD, BYTE_W'($urandom_range(0, 255)), 1'b1);
         push_fetches($urandom_range(1, 3), 1'b0);
      end
   endtask

   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_IMG_WIDTH;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single pixel image: early fetch, wrap, reload after completion
      write_dim(CSR_IMG_WIDTH, 8'd1);
      write_dim(CSR_IMG_HEIGHT, 8'd1);
      @(negedge clock);
      push_item(CMD_FETCH, 8'hFF, 1'b0);
      push_item(CMD_LOAD, 8'h00, 1'b0);
      push_item(CMD_LOAD, 8'hFF, 1'b0);
      push_item(CMD_LOAD, 8'hA5, 1'b0);
      push_item(CMD_LOAD, 8'h5A, 1'b0);
      push_fetches(5, 1'b0);
      push_item(CMD_LOAD, 8'h12, 1'b0);
      push_item(CMD_LOAD, 8'h34, 1'b0);
      push_item(CMD_FETCH, 8'h00, 1'b0);
      push_item(CMD_LOAD, 8'h56, 1'b0);
      push_item(CMD_LOAD, 8'h00, 1'b0);
      push_fetches(4, 1'b0);
      push_item(CMD_LOAD, 8'h80, 1'b0);
      push_item(CMD_LOAD, 8'h7F, 1'b0);
      // write with a half-loaded image, zero dimensions clip to one
      settle();
      write_dim(CSR_IMG_WIDTH, 8'd0);
      write_dim(CSR_IMG_HEIGHT, 8'd0);
      @(negedge clock);
      push_image(1, 1, 1'b0);
      push_fetches(4, 1'b0);

      // widest image, oversize width clipped; long hold-off on the responses
      settle();
      write_dim(CSR_IMG_WIDTH, 8'd255);
      write_dim(CSR_IMG_HEIGHT, 8'd1);
      @(negedge clock);
      push_image(MAX_DIM, 1, 1'b0);
      while (req_q.size() > 8)
         @(negedge clock);
      long_hold_req <= 1'b1;
      push_fetches(EDGE_FETCHES, 1'b0);

      // tallest image, oversize height clipped
      settle();
      write_dim(CSR_IMG_WIDTH, 8'd1);
      write_dim(CSR_IMG_HEIGHT, 8'd200);
      @(negedge clock);
      push_image(1, MAX_DIM, 1'b1);
      push_fetches(EDGE_FETCHES, 1'b0);

      queued_items = 0;
      while (queued_items < RANDOM_ITEMS) begin
         if (queued_items > RANDOM_ITEMS - 300)
            calm <= 1'b1;
         random_phase();
      end
      settle();
      repeat (8) @(posedge clock);

      if (rotated_q.size() != 0)
         $error("out_byte: %0d expected items never arrived", rotated_q.size());
      $display("Covered %0d completed images over %0d dimension writes,", images_done,
               dim_writes);
      $display("%0d source bytes loaded and %0d rotated bytes compared.", loads_taken,
               bytes_compared);
      if (fail_count == 0 && rotated_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
sv/bmpr_pkg.sv
sv/bmpr_req_if.sv
sv/bmpr_rsp_if.sv
sv/bmp_pixel_rotate_90_core.sv
sv/bmpr_checker.sv
tb/tb_top.sv
